/* hdl/binary_to_decimal_ascii_core_defines.svh */
// ----------------------------------------------------------------------------
// Binary to decimal ASCII core assertion macros
// Shared concurrent assertion forms used by the checker of the core.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define B2DA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b2da assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define B2DA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b2da assertion failed");

`endif

/* hdl/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// Binary to decimal ASCII package
// Widths, constants and shared types of the converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int unsigned ValueW    = 16;
  localparam int unsigned NumDigits = 5;
  localparam int unsigned BcdW      = 4 * NumDigits;
  localparam int unsigned AsciiW    = 6;
  localparam int unsigned ShiftCntW = $clog2(ValueW);
  localparam int unsigned IdxW      = $clog2(NumDigits);

  localparam logic [AsciiW-1:0]    AsciiZero = 6'd48;
  localparam logic [ShiftCntW-1:0] LastShift = ShiftCntW'(ValueW - 1);
  localparam logic [IdxW-1:0]      LastIdx   = IdxW'(NumDigits - 1);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StStart,
    StEmit
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic start_emit;
    logic next_digit;
  } cmd_t;

  typedef struct packed {
    logic shift_done;
    logic is_last;
  } sts_t;

endpackage

/* hdl/binary_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// Binary to decimal ASCII core
// Converts an unsigned 16-bit number into ASCII decimal digits.
// ----------------------------------------------------------------------------
// Each accepted number is converted by sixteen shift-and-add-three iterations,
// one per cycle, and then sent most significant digit first with leading
// zeros dropped, one digit per output transfer, the final digit flagged by
// last_o. A number passes through intake, the conversion, the search for the
// first digit and the digit transfers in that order; a new number is taken
// once the last digit of the previous one has been transferred.
module binary_to_decimal_ascii_core import b2da_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ValueW-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [AsciiW-1:0] ascii_digit_o,
  output logic              last_o
);

  cmd_t cmd;
  sts_t sts;

  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  b2da_datapath u_dp (
    .clk_i        (clk_i),
    .value_i      (value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .ascii_digit_o(ascii_digit_o),
    .last_o       (last_o)
  );

endmodule

/* hdl/b2da_datapath.sv */
// ----------------------------------------------------------------------------
// Binary to decimal ASCII datapath
// Shift-and-add-three conversion registers and the digit output selection.
// ----------------------------------------------------------------------------
module b2da_datapath import b2da_pkg::*; (
  input  logic              clk_i,
  input  logic [ValueW-1:0] value_i,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  output logic [AsciiW-1:0] ascii_digit_o,
  output logic              last_o
);

  logic [ValueW-1:0]    bin_q, bin_d;
  logic [BcdW-1:0]      bcd_q, bcd_d;
  logic [BcdW-1:0]      bcd_adj;
  logic [ShiftCntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [IdxW-1:0]      first_idx;
  logic [3:0]           digit;

  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      if (bcd_q[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
      end
    end
  end

  // Digit zero is the most significant one.
  always_comb begin
    priority if (bcd_q[19:16] != 4'd0) begin
      first_idx = IdxW'(0);
    end else if (bcd_q[15:12] != 4'd0) begin
      first_idx = IdxW'(1);
    end else if (bcd_q[11:8] != 4'd0) begin
      first_idx = IdxW'(2);
    end else if (bcd_q[7:4] != 4'd0) begin
      first_idx = IdxW'(3);
    end else begin
      first_idx = LastIdx;
    end
  end

  always_comb begin
    bin_d = bin_q;
    bcd_d = bcd_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (cmd_i.load) begin
      bin_d = value_i;
      bcd_d = '0;
      cnt_d = '0;
    end
    if (cmd_i.shift) begin
      bcd_d = {bcd_adj[BcdW-2:0], bin_q[ValueW-1]};
      bin_d = {bin_q[ValueW-2:0], 1'b0};
      cnt_d = cnt_q + ShiftCntW'(1);
    end
    if (cmd_i.start_emit) begin
      idx_d = first_idx;
    end
    if (cmd_i.next_digit) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
    cnt_q <= cnt_d;
    idx_q <= idx_d;
  end

  always_comb begin
    unique case (idx_q)
      3'd0:    digit = bcd_q[19:16];
      3'd1:    digit = bcd_q[15:12];
      3'd2:    digit = bcd_q[11:8];
      3'd3:    digit = bcd_q[7:4];
      3'd4:    digit = bcd_q[3:0];
      default: digit = 4'd0;
    endcase
  end

  assign ascii_digit_o     = AsciiZero | {2'b00, digit};
  assign last_o            = (idx_q == LastIdx);
  assign sts_o.shift_done  = (cnt_q == LastShift);
  assign sts_o.is_last     = (idx_q == LastIdx);

endmodule

/* hdl/b2da_ctrl.sv */
// ----------------------------------------------------------------------------
// Binary to decimal ASCII controller
// Sequences intake, the shift iterations and the digit transfers.
// ----------------------------------------------------------------------------
module b2da_ctrl import b2da_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_done) begin
          state_d = StStart;
        end
      end
      StStart: begin
        cmd_o.start_emit = 1'b1;
        state_d          = StEmit;
      end
      StEmit: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (sts_i.is_last) begin
            state_d = StIdle;
          end else begin
            cmd_o.next_digit = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

/* hdl/b2da_checker.sv */
// ----------------------------------------------------------------------------
// Binary to decimal ASCII checker
// Port-level assertions on the converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_to_decimal_ascii_core_defines.svh"

module b2da_checker import b2da_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [AsciiW-1:0] ascii_digit_o,
  input logic              last_o
);

  logic out_xfer;
  logic out_hold;
  logic digit_ok;

  assign out_xfer = out_valid_o && !out_stall_i;
  assign out_hold = out_valid_o && out_stall_i;
  assign digit_ok = (ascii_digit_o[5:4] == 2'b11) && (ascii_digit_o[3:0] <= 4'd9);

  `B2DA_ASSERT_NEXT(a_busy_after_intake, in_valid_i && !in_stall_o, in_stall_o)
  `B2DA_ASSERT_SAME(a_no_intake_while_emit, out_valid_o, in_stall_o)
  `B2DA_ASSERT_NEXT(a_run_continues, out_xfer && !last_o, out_valid_o)
  `B2DA_ASSERT_SAME(a_digit_code, out_valid_o, digit_ok)
  `B2DA_ASSERT_NEXT(a_stall_holds, out_hold, out_valid_o && $stable(ascii_digit_o) && $stable(last_o))

endmodule

bind binary_to_decimal_ascii_core b2da_checker u_b2da_checker (.*);

/* verif/binary_to_decimal_ascii_core_test.sv */
// ----------------------------------------------------------------------------
// Binary to decimal ASCII core testbench
// Sends numbers through the converter with random gaps and output stalls,
// predicts the decimal digit text of each transferred number and checks every
// output transfer, digit and last flag, against it in order.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core_test;
  import b2da_pkg::*;

  localparam int unsigned TopWeight  = 10000;
  localparam int unsigned DigitBase  = 10;
  localparam int unsigned NumRandom  = 207;
  localparam int unsigned QuietTail  = 30;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [AsciiW-1:0] ascii;
    logic              last;
  } digit_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic [ValueW-1:0] value_i       = '0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [AsciiW-1:0] ascii_digit_o;
  logic              last_o;

  logic [ValueW-1:0] pending_values[$];
  digit_t            expected_digits[$];
  int unsigned       in_gap        = 0;
  int unsigned       out_gap       = 0;
  int unsigned       err_count     = 0;
  int unsigned       cycle_count   = 0;
  logic              quiet;

  binary_to_decimal_ascii_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ascii_digit_o (ascii_digit_o),
    .last_o        (last_o)
  );

  assign quiet = (pending_values.size() < QuietTail);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Splits a number into decimal digits, most significant first, and drops
  // the leading zeros while always keeping the units digit.
  function automatic void push_decimal_digits(input logic [ValueW-1:0] number);
    int unsigned rest;
    int unsigned weight;
    int unsigned digit;
    logic        seen;
    digit_t      text[$];
    digit_t      item;
    rest   = number;
    weight = TopWeight;
    seen   = 1'b0;
    for (int k = 0; k < NumDigits; k++) begin
      digit = rest / weight;
      rest  = rest % weight;
      if (digit != 0 || seen || weight == 1) begin
        seen       = 1'b1;
        item.ascii = AsciiZero + AsciiW'(digit);
        item.last  = 1'b0;
        text.push_back(item);
      end
      weight = weight / DigitBase;
    end
    text[text.size() - 1].last = 1'b1;
    foreach (text[i]) expected_digits.push_back(text[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      value_i    <= '0;
      in_gap     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        push_decimal_digits(value_i);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_valid_i <= 1'b0;
          in_gap     <= in_gap - 1;
        end else if (pending_values.size() > 0) begin
          in_valid_i <= 1'b1;
          value_i    <= pending_values.pop_front();
          if (!quiet && $urandom_range(0, 4) == 0) begin
            in_gap <= $urandom_range(1, 11);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    digit_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap     <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_digits.size() == 0) begin
          err_count <= err_count + 1;
          $display("%0t: unexpected transfer, actual digit %0d last %0b",
                   $time, ascii_digit_o, last_o);
        end else begin
          want = expected_digits.pop_front();
          if (ascii_digit_o !== want.ascii || last_o !== want.last) begin
            err_count <= err_count + 1;
            $display("%0t: expected digit %0d last %0b, actual digit %0d last %0b",
                     $time, want.ascii, want.last, ascii_digit_o, last_o);
          end
        end
      end
      if (out_gap > 0) begin
        out_stall_i <= 1'b1;
        out_gap     <= out_gap - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        out_gap     <= $urandom_range(0, 10);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int unsigned n_digits;
    int unsigned lo;
    int unsigned hi;
    pending_values = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd19, 16'd99, 16'd100, 16'd101,
                       16'd999, 16'd1000, 16'd9999, 16'd10000, 16'd10001, 16'd65535,
                       16'd65534, 16'd32768, 16'd12345, 16'd60000, 16'd50505,
                       16'hAAAA, 16'h5555, 16'd0, 16'd7};
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        pending_values.push_back(ValueW'($urandom));
      end else begin
        n_digits = $urandom_range(1, NumDigits);
        lo = (n_digits == 1) ? 0 : 10 ** (n_digits - 1);
        hi = (n_digits == NumDigits) ? 65535 : 10 ** n_digits - 1;
        pending_values.push_back(ValueW'($urandom_range(hi, lo)));
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    do @(posedge clk_i);
    while (pending_values.size() > 0 || in_valid_i || expected_digits.size() > 0);
    repeat (DrainWait) @(posedge clk_i);
    if (err_count == 0 && expected_digits.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/b2da_pkg.sv
hdl/b2da_datapath.sv
hdl/b2da_ctrl.sv
hdl/binary_to_decimal_ascii_core.sv
hdl/b2da_checker.sv
verif/binary_to_decimal_ascii_core_test.sv
